>>> rtl/gcab_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcab_pkg: shared types for the glyph cell alpha blitter
// Configuration register indexes, register bank and pipeline stage types.
// ----------------------------------------------------------------------------
package gcab_pkg;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned DIM_W      = 9;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned COLOR_W    = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FG_COLOR    = 4'd0,
    REG_BG_COLOR    = 4'd1,
    REG_GLYPH_LEFT  = 4'd2,
    REG_GLYPH_TOP   = 4'd3,
    REG_GLYPH_WIDTH = 4'd4,
    REG_GLYPH_ROWS  = 4'd5,
    REG_CELL_WIDTH  = 4'd6,
    REG_CELL_HEIGHT = 4'd7
  } cfg_idx_t;

  // Dimensions are held already saturated to the glyph size limit.
  typedef struct packed {
    logic [COLOR_W-1:0]      fg;
    logic [COLOR_W-1:0]      bg;
    logic signed [DIM_W-1:0] left;
    logic signed [DIM_W-1:0] top;
    logic [DIM_W-1:0]        glyph_w;
    logic [DIM_W-1:0]        glyph_h;
    logic [DIM_W-1:0]        cell_w;
    logic [DIM_W-1:0]        cell_h;
  } cfg_t;

  // One accepted coverage byte with its bitmap position.
  typedef struct packed {
    logic [LEVEL_W-1:0] coverage;
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [DIM_W-1:0]   col;
    logic [DIM_W-1:0]   row;
    logic               in_bitmap;
  } stage_t;

endpackage
`default_nettype wire

>>> rtl/gcab_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcab_in_if: coverage byte request channel
// Valid/ready channel carrying one bitmap byte and the cell origin.
// ----------------------------------------------------------------------------
interface gcab_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  coverage;
  logic [11:0] origin_x;
  logic [11:0] origin_y;

  modport source (output valid, output coverage, output origin_x, output origin_y,
                  input ready);
  modport sink   (input valid, input coverage, input origin_x, input origin_y,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/gcab_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcab_out_if: blended pixel request channel
// Valid/ready channel carrying a screen coordinate and an RGB color.
// ----------------------------------------------------------------------------
interface gcab_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;

  modport source (output valid, output pixel_x, output pixel_y, output red,
                  output green, output blue, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input red,
                  input green, input blue, output ready);
endinterface
`default_nettype wire

>>> rtl/glyph_cell_alpha_blit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glyph_cell_alpha_blit: antialiased glyph blitter for one character cell
// Streams coverage bytes in row order and emits clipped, blended pixels.
// ----------------------------------------------------------------------------
// Usage:
//   in_px  : one coverage byte per request with the cell's screen origin,
//            bitmap bytes in row order. Column/row counters wrap after
//            glyph_width bytes and glyph_rows rows.
//   out_px : zero or one pixel per input request; bytes outside the bitmap
//            or outside the cell are dropped but still advance the counters.
//   cfg_*  : write-only registers by index (fg, bg, left, top, glyph width,
//            glyph rows, cell width, cell height). Write only while idle.
// Pipeline: out_px.valid is driven by the result register, which is loaded
//   from the input register that the input accept fills; one request per
//   cycle sustained while out_px.ready is high.
// Reset: counters zeroed, fg white, bg black, all geometry zero, so nothing
//   is emitted until the dimensions are programmed.
// Stall: a held output keeps its result register; the input register still
//   frees up while the output is empty, and in_px.ready drops only when both
//   stages are full.
// ----------------------------------------------------------------------------
module glyph_cell_alpha_blit
  import gcab_pkg::*;
#(
  parameter int MAX_GLYPH_DIM = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  gcab_in_if.sink                    in_px,
  gcab_out_if.source                 out_px,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t   cfg;
  logic   stg_valid;
  stage_t stg;
  logic   stg_ready;

  // register bank, dimensions saturated at write
  gcab_cfg_regs #(
    .MaxDim (MAX_GLYPH_DIM)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // position counters + input register
  gcab_walker u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_req    (in_px),
    .stg_valid (stg_valid),
    .stg       (stg),
    .stg_ready (stg_ready)
  );

  // clip, coordinate, blend into result register
  gcab_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .stg_valid (stg_valid),
    .stg       (stg),
    .stg_ready (stg_ready),
    .out_px    (out_px)
  );

endmodule
`default_nettype wire

>>> rtl/gcab_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcab_cfg_regs: configuration register bank
// Write-only registers; dimensions are saturated to the limit on write.
// ----------------------------------------------------------------------------
module gcab_cfg_regs
  import gcab_pkg::*;
#(
  parameter int MaxDim = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  cfg_t             cfg_r;
  cfg_t             cfg_nxt;
  logic [DIM_W-1:0] v9;
  logic [DIM_W-1:0] dim_sat;

  assign v9      = cfg_wdata[DIM_W-1:0];
  assign dim_sat = (int'(v9) > MaxDim) ? DIM_W'(MaxDim) : v9;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        REG_FG_COLOR:    cfg_nxt.fg      = cfg_wdata[COLOR_W-1:0];
        REG_BG_COLOR:    cfg_nxt.bg      = cfg_wdata[COLOR_W-1:0];
        REG_GLYPH_LEFT:  cfg_nxt.left    = $signed(v9);
        REG_GLYPH_TOP:   cfg_nxt.top     = $signed(v9);
        REG_GLYPH_WIDTH: cfg_nxt.glyph_w = dim_sat;
        REG_GLYPH_ROWS:  cfg_nxt.glyph_h = dim_sat;
        REG_CELL_WIDTH:  cfg_nxt.cell_w  = dim_sat;
        REG_CELL_HEIGHT: cfg_nxt.cell_h  = dim_sat;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // fg is the top field: white foreground, everything else zero
      cfg_r <= {{COLOR_W{1'b1}}, {($bits(cfg_t) - COLOR_W){1'b0}}};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

>>> rtl/gcab_walker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcab_walker: bitmap position counters and input register
// Tags each accepted byte with its column/row and advances the counters.
// ----------------------------------------------------------------------------
module gcab_walker
  import gcab_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  cfg_t       cfg,
  gcab_in_if.sink    in_req,
  output logic       stg_valid,
  output stage_t     stg,
  input  wire logic  stg_ready
);

  logic             stg_v_r;
  stage_t           stg_r;
  logic [DIM_W-1:0] col_r, col_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;
  logic             accept;
  logic [DIM_W:0]   col_inc;
  logic [DIM_W:0]   row_inc;

  assign in_req.ready = !stg_v_r || stg_ready;
  assign accept       = in_req.valid && in_req.ready;

  assign col_inc = {1'b0, col_r} + 1'b1;
  assign row_inc = {1'b0, row_r} + 1'b1;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (cfg.glyph_w == '0 || cfg.glyph_h == '0) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_inc >= {1'b0, cfg.glyph_w}) begin
        col_nxt = '0;
        row_nxt = (row_inc >= {1'b0, cfg.glyph_h}) ? '0 : row_inc[DIM_W-1:0];
      end else begin
        col_nxt = col_inc[DIM_W-1:0];
        if (row_r >= cfg.glyph_h) begin
          row_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      stg_v_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (in_req.ready) begin
        stg_v_r <= in_req.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_r.coverage  <= in_req.coverage;
      stg_r.origin_x  <= in_req.origin_x;
      stg_r.origin_y  <= in_req.origin_y;
      stg_r.col       <= col_r;
      stg_r.row       <= row_r;
      stg_r.in_bitmap <= (col_r < cfg.glyph_w) && (row_r < cfg.glyph_h);
    end
  end

  assign stg_valid = stg_v_r;
  assign stg       = stg_r;

endmodule
`default_nettype wire

>>> rtl/gcab_blend.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcab_blend: cell clipping, screen coordinates and color blend
// Computes one pixel from the input register into the result register.
// ----------------------------------------------------------------------------
module gcab_blend
  import gcab_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  cfg_t       cfg,
  input  wire logic  stg_valid,
  input  stage_t     stg,
  output logic       stg_ready,
  gcab_out_if.source out_px
);

  // bg + floor(level * (fg - bg) / 256), low 8 bits
  function automatic logic [7:0] mix(input logic [7:0] level, input logic [7:0] f,
                                     input logic [7:0] b);
    logic signed [8:0]  d;
    logic signed [17:0] p;
    logic signed [17:0] q;
    d   = $signed({1'b0, f}) - $signed({1'b0, b});
    p   = $signed({1'b0, level}) * d;
    q   = p >>> 8;
    mix = b + q[7:0];
  endfunction

  logic signed [DIM_W+1:0] cx;
  logic signed [DIM_W+1:0] cy;
  logic                    in_cell;
  logic                    visible;
  logic                    out_v_r;
  logic [COORD_W-1:0]      px_r, py_r;
  logic [7:0]              red_r, green_r, blue_r;

  assign cx = $signed({{2{cfg.left[DIM_W-1]}}, cfg.left}) + $signed({2'b00, stg.col});
  assign cy = $signed({{2{cfg.top[DIM_W-1]}}, cfg.top}) + $signed({2'b00, stg.row});

  assign in_cell = !cx[DIM_W+1] && (cx[DIM_W:0] < {1'b0, cfg.cell_w}) &&
                   !cy[DIM_W+1] && (cy[DIM_W:0] < {1'b0, cfg.cell_h});
  assign visible = stg.in_bitmap && in_cell;

  assign stg_ready = !out_v_r || out_px.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (stg_ready) begin
      out_v_r <= stg_valid && visible;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_ready && stg_valid) begin
      px_r    <= stg.origin_x + COORD_W'(cx);
      py_r    <= stg.origin_y + COORD_W'(cy);
      red_r   <= mix(stg.coverage, cfg.fg[23:16], cfg.bg[23:16]);
      green_r <= mix(stg.coverage, cfg.fg[15:8],  cfg.bg[15:8]);
      blue_r  <= mix(stg.coverage, cfg.fg[7:0],   cfg.bg[7:0]);
    end
  end

  assign out_px.valid   = out_v_r;
  assign out_px.pixel_x = px_r;
  assign out_px.pixel_y = py_r;
  assign out_px.red     = red_r;
  assign out_px.green   = green_r;
  assign out_px.blue    = blue_r;

endmodule
`default_nettype wire
